[rtl/core/qslerp_pkg.sv]
// shared constants, types and helpers for the slerp core
`default_nettype none
package qslerp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ONE_Q15 = 32768;
  localparam logic [31:0] GAIN_INV = 32'd652032874;

  localparam logic [0:0] ADDR_THRESHOLD = 1'b0;

  function automatic logic signed [33:0] atan_q30(input int idx);
    logic signed [33:0] r;
    case (idx)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/quaternion_slerp_core.sv]
// quaternion slerp top level: dot, angle, sines, weights, normalization
`default_nettype none
// Fully pipelined slerp of two Q1.15 quaternions. One item enters every cycle
// unless a held result stalls the pipe. It has three front stages, two
// 32-stage square roots, two 48-stage divide chains, the two CORDIC passes of
// CORDIC_STEPS (16) stages each and seven single stages. A stall
// on the result side freezes the whole pipeline; in_stall then follows out_stall.
module quaternion_slerp_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] in_a_x,
  input  wire logic signed [15:0] in_a_y,
  input  wire logic signed [15:0] in_a_z,
  input  wire logic signed [15:0] in_a_w,
  input  wire logic signed [15:0] in_b_x,
  input  wire logic signed [15:0] in_b_y,
  input  wire logic signed [15:0] in_b_z,
  input  wire logic signed [15:0] in_b_w,
  input  wire logic        [15:0] in_blend,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic             out_used_linear
);
  import qslerp_pkg::*;

  localparam int LSQ = 32;
  localparam int LDV = 48;

  // ---------------- configuration ----------------
  logic [14:0] thr_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_THRESHOLD) ? {17'd0, thr_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'h7fff;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == ADDR_THRESHOLD) begin
      thr_r <= cfg_pwdata[14:0];
    end
  end

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // side data carried along the pipe up to the weighted sum
  typedef struct packed {
    logic signed [15:0] a0, a1, a2, a3, b0, b1, b2, b3;
    logic [15:0] t;
    logic neg;
    logic lin;
  } side_t;

  // ---------------- stage 1: products ----------------
  logic v1_r;
  side_t s1_r;
  logic signed [31:0] p_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side_t sd;
      sd.a0 = in_a_x; sd.a1 = in_a_y; sd.a2 = in_a_z; sd.a3 = in_a_w;
      sd.b0 = in_b_x; sd.b1 = in_b_y; sd.b2 = in_b_z; sd.b3 = in_b_w;
      sd.t = (in_blend > 16'd32768) ? 16'd32768 : in_blend;
      sd.neg = 1'b0;
      sd.lin = 1'b0;
      s1_r <= sd;
      p_r[0] <= in_a_x * in_b_x;
      p_r[1] <= in_a_y * in_b_y;
      p_r[2] <= in_a_z * in_b_z;
      p_r[3] <= in_a_w * in_b_w;
    end
  end

  // ---------------- stage 2: dot, c30, linear decision ----------------
  logic v2_r;
  side_t s2_r;
  logic [30:0] c30_r;
  logic signed [33:0] dot;
  logic [33:0] ad;
  always_comb begin
    dot = 34'(p_r[0]) + 34'(p_r[1]) + 34'(p_r[2]) + 34'(p_r[3]);
    ad = dot[33] ? 34'(-dot) : 34'(dot);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [30:0] c;
      side_t sd;
      c = (ad > 34'h40000000) ? 31'h40000000 : ad[30:0];
      sd = s1_r;
      sd.neg = dot[33];
      sd.lin = (c[30:15] > {1'b0, thr_r});
      c30_r <= c;
      s2_r <= sd;
    end
  end

  // ---------------- stage 3: 1 - c^2 ----------------
  logic v3_r;
  side_t s3_r;
  logic [30:0] c30b_r;
  logic [63:0] rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s2_r;
      c30b_r <= c30_r;
      rad_r <= (64'd1 << 60) - {33'd0, c30_r} * {33'd0, c30_r};
    end
  end

  // ---------------- sqrt for sine of angle ----------------
  logic [31:0] s30;
  qslerp_sqrt u_sq1 (.clk(clk), .adv(adv), .rad(rad_r), .root(s30));

  logic  vq_r [LSQ+1];
  side_t sq_r [LSQ+1];
  logic [30:0] cq_r [LSQ+1];
  always_comb begin
    vq_r[0] = v3_r; sq_r[0] = s3_r; cq_r[0] = c30b_r;
  end
  for (genvar i = 0; i < LSQ; i++) begin : g_sqd
    always_ff @(posedge clk) begin
      if (!rst_n) vq_r[i+1] <= 1'b0;
      else if (adv) vq_r[i+1] <= vq_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[i+1] <= sq_r[i];
        cq_r[i+1] <= cq_r[i];
      end
    end
  end

  // ---------------- CORDIC vectoring: angle ----------------
  localparam int NS = CORDIC_STEPS;
  logic signed [35:0] vx_r [NS+1];
  logic signed [35:0] vy_r [NS+1];
  logic signed [35:0] vz_r [NS+1];
  logic [31:0] vs_r [NS+1];
  logic  va_r [NS+1];
  side_t vsd_r [NS+1];
  always_comb begin
    vx_r[0] = 36'(cq_r[LSQ]);
    vy_r[0] = 36'(s30);
    vz_r[0] = '0;
    vs_r[0] = s30;
    va_r[0] = vq_r[LSQ];
    vsd_r[0] = sq_r[LSQ];
  end
  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!rst_n) va_r[i+1] <= 1'b0;
      else if (adv) va_r[i+1] <= va_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!vy_r[i][35]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + 36'(atan_q30(i));
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - 36'(atan_q30(i));
        end
        vs_r[i+1] <= vs_r[i];
        vsd_r[i+1] <= vsd_r[i];
      end
    end
  end

  // ---------------- angle split: ft and th-ft ----------------
  logic vf_r;
  side_t sf_r;
  logic [31:0] sf30_r;
  logic signed [35:0] ft_r, fr_r;
  logic [33:0] th_c;
  logic [49:0] thm;
  always_comb begin
    th_c = vz_r[NS][35] ? 34'd0 : vz_r[NS][33:0];
    thm = {16'd0, th_c} * {34'd0, vsd_r[NS].t};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (adv) vf_r <= va_r[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sf_r <= vsd_r[NS];
      sf30_r <= vs_r[NS];
      ft_r <= $signed({1'b0, thm[49:15]});
      fr_r <= $signed({2'b0, th_c}) - $signed({1'b0, thm[49:15]});
    end
  end

  // ---------------- CORDIC rotation: two sines ----------------
  logic signed [35:0] rx_r [2][NS+1];
  logic signed [35:0] ry_r [2][NS+1];
  logic signed [35:0] rz_r [2][NS+1];
  logic [31:0] rs_r [NS+1];
  logic  rv_r [NS+1];
  side_t rsd_r [NS+1];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rx_r[l][0] = 36'(GAIN_INV);
      ry_r[l][0] = '0;
    end
    rz_r[0][0] = ft_r;
    rz_r[1][0] = fr_r;
    rs_r[0] = sf30_r;
    rv_r[0] = vf_r;
    rsd_r[0] = sf_r;
  end
  for (genvar i = 0; i < NS; i++) begin : g_rot
    for (genvar l = 0; l < 2; l++) begin : g_ln
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!rz_r[l][i][35]) begin
            rx_r[l][i+1] <= rx_r[l][i] - (ry_r[l][i] >>> i);
            ry_r[l][i+1] <= ry_r[l][i] + (rx_r[l][i] >>> i);
            rz_r[l][i+1] <= rz_r[l][i] - 36'(atan_q30(i));
          end else begin
            rx_r[l][i+1] <= rx_r[l][i] + (ry_r[l][i] >>> i);
            ry_r[l][i+1] <= ry_r[l][i] - (rx_r[l][i] >>> i);
            rz_r[l][i+1] <= rz_r[l][i] + 36'(atan_q30(i));
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[i+1] <= 1'b0;
      else if (adv) rv_r[i+1] <= rv_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rs_r[i+1] <= rs_r[i];
        rsd_r[i+1] <= rsd_r[i];
      end
    end
  end

  // ---------------- weight division: sine * 2^15 / s30 ----------------
  // divides magnitudes, sign is restored afterwards (truncation toward zero)
  logic [47:0] wn [2];
  logic [1:0] wsg;
  logic [31:0] wden;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic signed [35:0] sv;
      logic [35:0] mg;
      sv = ry_r[l][NS];
      wsg[l] = sv[35];
      mg = sv[35] ? 36'(-sv) : 36'(sv);
      wn[l] = {mg[32:0], 15'd0};
    end
    wden = (rs_r[NS] == 32'd0) ? 32'd1 : rs_r[NS];
  end
  logic [47:0] wq [2];
  qslerp_div u_dw0 (.clk(clk), .adv(adv), .num(wn[0]), .den(wden), .quo(wq[0]));
  qslerp_div u_dw1 (.clk(clk), .adv(adv), .num(wn[1]), .den(wden), .quo(wq[1]));

  logic  dv_r [LDV+1];
  side_t dsd_r [LDV+1];
  logic [1:0] dsg_r [LDV+1];
  always_comb begin
    dv_r[0] = rv_r[NS]; dsd_r[0] = rsd_r[NS]; dsg_r[0] = wsg;
  end
  for (genvar i = 0; i < LDV; i++) begin : g_dwd
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else if (adv) dv_r[i+1] <= dv_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dsd_r[i+1] <= dsd_r[i];
        dsg_r[i+1] <= dsg_r[i];
      end
    end
  end

  // ---------------- weights selection ----------------
  logic vw_r;
  side_t sw_r;
  logic signed [18:0] f1_r, f2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vw_r <= 1'b0;
    else if (adv) vw_r <= dv_r[LDV];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [18:0] g1, g2;
      side_t sd;
      sd = dsd_r[LDV];
      if (sd.lin) begin
        g2 = $signed({3'b0, sd.t});
        g1 = 19'sd32768 - $signed({3'b0, sd.t});
      end else begin
        // quotients stay within two Q1.15 units for valid spherical cases
        g2 = dsg_r[LDV][0] ? -$signed({1'b0, wq[0][17:0]}) : $signed({1'b0, wq[0][17:0]});
        g1 = dsg_r[LDV][1] ? -$signed({1'b0, wq[1][17:0]}) : $signed({1'b0, wq[1][17:0]});
      end
      f1_r <= g1;
      f2_r <= sd.neg ? -g2 : g2;
      sw_r <= sd;
    end
  end

  // ---------------- weighted sum ----------------
  logic vm_r;
  logic lin_m_r;
  logic signed [34:0] m1_r [4], m2_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (adv) vm_r <= vw_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r[0] <= f1_r * sw_r.a0; m2_r[0] <= f2_r * sw_r.b0;
      m1_r[1] <= f1_r * sw_r.a1; m2_r[1] <= f2_r * sw_r.b1;
      m1_r[2] <= f1_r * sw_r.a2; m2_r[2] <= f2_r * sw_r.b2;
      m1_r[3] <= f1_r * sw_r.a3; m2_r[3] <= f2_r * sw_r.b3;
      lin_m_r <= sw_r.lin;
    end
  end

  logic ve_r;
  logic lin_e_r;
  logic signed [35:0] vs_sum_r [4];
  logic [35:0] mx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (adv) ve_r <= vm_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [35:0] s;
      logic [35:0] mg, mx;
      mx = '0;
      for (int i = 0; i < 4; i++) begin
        s = 36'(m1_r[i]) + 36'(m2_r[i]);
        vs_sum_r[i] <= s;
        mg = s[35] ? 36'(-s) : 36'(s);
        if (mg > mx) mx = mg;
      end
      mx_r <= mx;
      lin_e_r <= lin_m_r;
    end
  end

  // ---------------- scale: smallest k with max >> k below 2^30 ----------------
  logic vk_r;
  logic lin_k_r;
  logic signed [30:0] w_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) vk_r <= 1'b0;
    else if (adv) vk_r <= ve_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [2:0] k;
      logic signed [35:0] sh;
      k = 3'd0;
      for (int j = 5; j >= 1; j--) begin
        if ((mx_r >> j) >= 36'h40000000 && k == 3'd0) k = 3'(j + 1);
      end
      if (k == 3'd0 && mx_r >= 36'h40000000) k = 3'd1;
      if (k > 3'd5) k = 3'd6;
      for (int i = 0; i < 4; i++) begin
        sh = vs_sum_r[i] >>> k;
        w_r[i] <= sh[30:0];
      end
      lin_k_r <= lin_e_r;
    end
  end

  logic vs2_r;
  logic lin_s_r;
  logic signed [30:0] ws_r [4];
  logic [63:0] ssq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vs2_r <= 1'b0;
    else if (adv) vs2_r <= vk_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < 4; i++) acc = acc + 64'(unsigned'(62'(w_r[i] * w_r[i])));
      ssq_r <= acc;
      ws_r <= w_r;
      lin_s_r <= lin_k_r;
    end
  end

  logic [31:0] mag;
  qslerp_sqrt u_sq2 (.clk(clk), .adv(adv), .rad(ssq_r), .root(mag));

  logic  nv_r [LSQ+1];
  logic  nl_r [LSQ+1];
  logic signed [30:0] nw_r [LSQ+1][4];
  always_comb begin
    nv_r[0] = vs2_r; nl_r[0] = lin_s_r; nw_r[0] = ws_r;
  end
  for (genvar i = 0; i < LSQ; i++) begin : g_nd
    always_ff @(posedge clk) begin
      if (!rst_n) nv_r[i+1] <= 1'b0;
      else if (adv) nv_r[i+1] <= nv_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        nl_r[i+1] <= nl_r[i];
        nw_r[i+1] <= nw_r[i];
      end
    end
  end

  // ---------------- final division ----------------
  logic [47:0] on [4];
  logic [3:0] osg;
  logic [31:0] oden;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [30:0] c;
      logic [30:0] mg;
      c = nw_r[LSQ][i];
      osg[i] = c[30];
      mg = c[30] ? 31'(-c) : 31'(c);
      on[i] = {2'b0, mg, 15'd0};
    end
    oden = (mag == 32'd0) ? 32'd1 : mag;
  end
  logic [47:0] oq [4];
  for (genvar i = 0; i < 4; i++) begin : g_od
    qslerp_div u_do (.clk(clk), .adv(adv), .num(on[i]), .den(oden), .quo(oq[i]));
  end

  logic ov_r [LDV+1];
  logic ol_r [LDV+1];
  logic oz_r [LDV+1];
  logic [3:0] os_r [LDV+1];
  always_comb begin
    ov_r[0] = nv_r[LSQ]; ol_r[0] = nl_r[LSQ]; oz_r[0] = (mag == 32'd0); os_r[0] = osg;
  end
  for (genvar i = 0; i < LDV; i++) begin : g_odd
    always_ff @(posedge clk) begin
      if (!rst_n) ov_r[i+1] <= 1'b0;
      else if (adv) ov_r[i+1] <= ov_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ol_r[i+1] <= ol_r[i];
        oz_r[i+1] <= oz_r[i];
        os_r[i+1] <= os_r[i];
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [15:0] res [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (oz_r[LDV]) begin
        res[i] = (i == 3) ? 16'sd32767 : 16'sd0;
      end else if (os_r[LDV][i]) begin
        res[i] = (oq[i] > 48'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, oq[i][16:0]}));
      end else begin
        res[i] = (oq[i] > 48'd32767) ? 16'sd32767 : $signed(oq[i][15:0]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= ov_r[LDV];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_w <= res[3];
      out_used_linear <= ol_r[LDV];
    end
  end

  // held beat stays put while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_w))
    else $error("result beat changed under stall");
  a_install: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ov_r[LDV] && oz_r[LDV] |=> out_w == 16'sd32767 && out_x == 16'sd0)
    else $error("zero-length sum not mapped to identity");
endmodule
`default_nettype wire

[rtl/core/qslerp_sqrt.sv]
// pipelined integer square root, one result bit per stage, 64-bit radicand
`default_nettype none
module qslerp_sqrt (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [63:0] rad,
  output logic      [31:0] root
);
  import qslerp_pkg::*;

  // restoring method: stage s settles root bit 31-s
  logic [63:0] rem_r [33];
  logic [31:0] q_r   [33];

  always_comb begin
    rem_r[0] = rad;
    q_r[0] = '0;
  end

  for (genvar s = 0; s < 32; s++) begin : g_st
    logic [63:0] trial;
    logic [63:0] rem_n;
    logic [31:0] q_n;
    always_comb begin
      trial = ({32'd0, q_r[s]} << (32 - s)) | (64'd1 << (62 - 2 * s));
      if (rem_r[s] >= trial) begin
        rem_n = rem_r[s] - trial;
        q_n = q_r[s] | (32'd1 << (31 - s));
      end else begin
        rem_n = rem_r[s];
        q_n = q_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= rem_n;
        q_r[s+1] <= q_n;
      end
    end
  end

  assign root = q_r[32];
endmodule
`default_nettype wire

[rtl/core/qslerp_div.sv]
// pipelined restoring divider, unsigned 48-bit dividend over 32-bit divisor
`default_nettype none
module qslerp_div (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [47:0] num,
  input  wire logic [31:0] den,
  output logic      [47:0] quo
);
  import qslerp_pkg::*;

  logic [31:0] rem_r [49];
  logic [47:0] n_r   [49];
  logic [31:0] d_r   [49];

  always_comb begin
    rem_r[0] = '0;
    n_r[0] = num;
    d_r[0] = den;
  end

  for (genvar s = 0; s < 48; s++) begin : g_st
    logic [32:0] sh;
    logic [31:0] rem_n;
    logic [47:0] n_n;
    always_comb begin
      sh = {rem_r[s], n_r[s][47]};
      n_n = {n_r[s][46:0], 1'b0};
      if (sh >= {1'b0, d_r[s]}) begin
        rem_n = 32'(sh - {1'b0, d_r[s]});
        n_n[0] = 1'b1;
      end else begin
        rem_n = sh[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= rem_n;
        n_r[s+1] <= n_n;
        d_r[s+1] <= d_r[s];
      end
    end
  end

  assign quo = n_r[48];
endmodule
`default_nettype wire
